[design/led_fade_pattern_sequencer_macros.svh]
// Assertion helpers for the module that checks its own behavior.
`ifndef LED_FADE_PATTERN_SEQUENCER_MACROS_SVH
`define LED_FADE_PATTERN_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LFPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lfps_pkg.sv]
`timescale 1ns / 1ps

package lfps_pkg;

  localparam int unsigned REQ_W       = 2;
  localparam int unsigned ENTRY_W     = 5;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned RGB_W       = 3 * COLOR_W;
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned MAG_W       = 15;
  localparam int unsigned REM_W       = COLOR_W + 1;
  localparam int unsigned LEVEL_SHIFT = 7;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned CNT_W       = 4;

  localparam logic [COLOR_W-1:0] REPEAT_HOLD = 8'hFF;
  localparam logic [CNT_W-1:0]   DIV_LAST    = CNT_W'(MAG_W - 1);

  typedef logic [1:0] chan_t;

  localparam chan_t CH_RED   = 2'd0;
  localparam chan_t CH_GREEN = 2'd1;
  localparam chan_t CH_BLUE  = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_ENTRY  = 2'd1,
    REQ_HEADER = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_LOAD,
    ST_DIV,
    ST_STORE,
    ST_ADVANCE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic  write;
    logic  step;
    logic  load;
    logic  iter;
    logic  store;
    logic  advance;
    logic  load_out;
    chan_t chan;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic fade_start;
    logic out_free;
  } sts_t;

endpackage

[design/lfps_in_if.sv]
`timescale 1ns / 1ps

interface lfps_in_if;
  import lfps_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [ENTRY_W-1:0] entry_index;
  logic [COLOR_W-1:0] red_level;
  logic [COLOR_W-1:0] green_level;
  logic [COLOR_W-1:0] blue_level;
  logic [COLOR_W-1:0] step_period;
  logic [COLOR_W-1:0] fade_ticks;
  logic [COLOR_W-1:0] repeat_limit;

  modport source (
    output valid, req_type, entry_index, red_level, green_level, blue_level,
           step_period, fade_ticks, repeat_limit,
    input  ready
  );

  modport sink (
    input  valid, req_type, entry_index, red_level, green_level, blue_level,
           step_period, fade_ticks, repeat_limit,
    output ready
  );

endinterface

[design/lfps_out_if.sv]
`timescale 1ns / 1ps

interface lfps_out_if;
  import lfps_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red_out;
  logic [COLOR_W-1:0] green_out;
  logic [COLOR_W-1:0] blue_out;
  logic               pattern_done;

  modport source (
    output valid, red_out, green_out, blue_out, pattern_done,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out, pattern_done,
    output ready
  );

endinterface

[design/lfps_ctrl.sv]
`timescale 1ns / 1ps

module lfps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lfps_pkg::sts_t sts_i,
  output lfps_pkg::cmd_t cmd_o
);
  import lfps_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  chan_t             ch_q, ch_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ch_q    <= CH_RED;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ch_q    <= ch_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ch_d       = ch_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.chan = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (sts_i.is_tick) begin
            state_d = ST_STEP;
          end else begin
            cmd_o.write = 1'b1;
            state_d     = ST_RESULT;
          end
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        ch_d       = CH_RED;
        state_d    = sts_i.fade_start ? ST_LOAD : ST_ADVANCE;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.iter = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (ch_q == CH_BLUE) begin
          ch_d    = CH_RED;
          state_d = ST_ADVANCE;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_ADVANCE: begin
        cmd_o.advance = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[design/lfps_datapath.sv]
`timescale 1ns / 1ps

module lfps_datapath #(
  parameter int unsigned PATTERN_LEN = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lfps_pkg::cmd_t           cmd_i,
  output lfps_pkg::sts_t           sts_o,
  input  logic [1:0]               req_type_i,
  input  logic [4:0]               entry_index_i,
  input  logic [7:0]               red_level_i,
  input  logic [7:0]               green_level_i,
  input  logic [7:0]               blue_level_i,
  input  logic [7:0]               step_period_i,
  input  logic [7:0]               fade_ticks_i,
  input  logic [7:0]               repeat_limit_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               red_out_o,
  output logic [7:0]               green_out_o,
  output logic [7:0]               blue_out_o,
  output logic                     pattern_done_o
);
  import lfps_pkg::*;

  localparam int unsigned AW = $clog2(PATTERN_LEN);
  localparam int unsigned IW = 9;
  localparam logic [AW-1:0] POS_LAST = AW'(PATTERN_LEN - 1);

  logic [RGB_W-1:0]   mem [PATTERN_LEN];
  logic [PATTERN_LEN-1:0] valid_q;
  logic [RGB_W-1:0]   rdata_q;
  logic               rvalid_q;

  logic [COLOR_W-1:0] hdr_period_q, hdr_fade_q, hdr_repeat_q;
  logic               restart_q, restart_d;
  logic               done_q, done_d;
  logic [COLOR_W-1:0] countdown_q, countdown_d, count_base;
  logic [AW-1:0]      pos_q, pos_d;
  logic [COLOR_W-1:0] repeat_q, repeat_d;

  logic signed [LEVEL_W-1:0] target_q [NUM_CH];
  logic signed [LEVEL_W-1:0] step_q   [NUM_CH];
  logic signed [LEVEL_W-1:0] level_q  [NUM_CH];
  logic signed [LEVEL_W-1:0] level_nx [NUM_CH];
  logic signed [LEVEL_W:0]   adv_diff [NUM_CH];
  logic signed [LEVEL_W:0]   adv_mag  [NUM_CH];
  logic signed [LEVEL_W:0]   inc_ext  [NUM_CH];
  logic signed [LEVEL_W:0]   inc_mag  [NUM_CH];

  logic [REM_W-1:0]   rem_q, rem_shift;
  logic [MAG_W-1:0]   quo_q;
  logic               neg_q;
  logic [COLOR_W-1:0] divisor;

  logic [RGB_W-1:0]          color_sel;
  logic [COLOR_W-1:0]        chan_color;
  logic signed [LEVEL_W-1:0] chan_level;
  logic signed [LEVEL_W-1:0] load_target;
  logic signed [LEVEL_W:0]   load_diff;
  logic signed [LEVEL_W:0]   load_mag;
  logic signed [LEVEL_W-1:0] quo_signed;

  logic [IW-1:0]      wr_index;
  logic               wr_ok;
  logic [AW-1:0]      wr_addr;
  logic               out_valid_q;
  logic               is_entry, is_header;

  assign is_entry  = cmd_i.write && (req_e'(req_type_i) == REQ_ENTRY);
  assign is_header = cmd_i.write && (req_e'(req_type_i) == REQ_HEADER);
  assign wr_index  = IW'(entry_index_i);
  assign wr_ok     = wr_index < IW'(PATTERN_LEN);
  assign wr_addr   = AW'(wr_index);

  assign sts_o.is_tick    = req_e'(req_type_i) == REQ_TICK;
  assign sts_o.fade_start = !restart_q && (countdown_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Pattern sequencing for one tick.
  always_comb begin
    restart_d   = restart_q;
    done_d      = done_q;
    countdown_d = countdown_q;
    pos_d       = pos_q;
    repeat_d    = repeat_q;
    count_base  = countdown_q;
    if (is_entry || is_header) begin
      restart_d = 1'b1;
    end
    if (cmd_i.step) begin
      if (restart_q) begin
        restart_d   = 1'b0;
        done_d      = 1'b0;
        countdown_d = '0;
        pos_d       = '0;
      end else begin
        if (countdown_q == '0) begin
          count_base = hdr_period_q;
          if (pos_q != POS_LAST) begin
            done_d   = 1'b0;
            pos_d    = pos_q + 1'b1;
            repeat_d = '0;
          end else begin
            done_d = 1'b1;
            if (hdr_repeat_q != REPEAT_HOLD) begin
              repeat_d = repeat_q + 1'b1;
              if (repeat_d > hdr_repeat_q) begin
                pos_d = '0;
              end
            end
          end
        end
        countdown_d = count_base - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_period_q <= '0;
      hdr_fade_q   <= '0;
      hdr_repeat_q <= '0;
      restart_q    <= 1'b0;
      done_q       <= 1'b0;
      countdown_q  <= '0;
      pos_q        <= '0;
      repeat_q     <= '0;
      valid_q      <= '0;
    end else begin
      restart_q   <= restart_d;
      done_q      <= done_d;
      countdown_q <= countdown_d;
      pos_q       <= pos_d;
      repeat_q    <= repeat_d;
      if (is_header) begin
        hdr_period_q <= step_period_i;
        hdr_fade_q   <= fade_ticks_i;
        hdr_repeat_q <= repeat_limit_i;
      end
      if (is_entry && wr_ok) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_entry && wr_ok) begin
      mem[wr_addr] <= {red_level_i, green_level_i, blue_level_i};
    end
    if (cmd_i.step) begin
      rdata_q  <= mem[pos_d];
      rvalid_q <= valid_q[pos_d];
    end
  end

  // Fade setup and the shared restoring divider.
  assign color_sel = rvalid_q ? rdata_q : '0;
  assign divisor   = (hdr_fade_q == '0) ? COLOR_W'(1) : hdr_fade_q;
  assign rem_shift = {rem_q[COLOR_W-1:0], quo_q[MAG_W-1]};

  always_comb begin
    unique case (cmd_i.chan)
      CH_RED: begin
        chan_color = color_sel[3*COLOR_W-1:2*COLOR_W];
        chan_level = level_q[0];
      end
      CH_GREEN: begin
        chan_color = color_sel[2*COLOR_W-1:COLOR_W];
        chan_level = level_q[1];
      end
      default: begin
        chan_color = color_sel[COLOR_W-1:0];
        chan_level = level_q[2];
      end
    endcase
  end

  assign load_target = {1'b0, chan_color, LEVEL_SHIFT'(0)};
  assign load_diff   = (LEVEL_W+1)'(load_target) - (LEVEL_W+1)'(chan_level);
  assign load_mag    = load_diff[LEVEL_W] ? -load_diff : load_diff;
  assign quo_signed  = neg_q ? -LEVEL_W'({1'b0, quo_q}) : LEVEL_W'({1'b0, quo_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= '0;
      quo_q <= load_mag[MAG_W-1:0];
      neg_q <= load_diff[LEVEL_W];
    end else if (cmd_i.iter) begin
      if (rem_shift >= REM_W'(divisor)) begin
        rem_q <= rem_shift - REM_W'(divisor);
        quo_q <= {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift;
        quo_q <= {quo_q[MAG_W-2:0], 1'b0};
      end
    end
  end

  // Per-channel level update toward the target.
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      adv_diff[i] = (LEVEL_W+1)'(target_q[i]) - (LEVEL_W+1)'(level_q[i]);
      adv_mag[i]  = adv_diff[i][LEVEL_W] ? -adv_diff[i] : adv_diff[i];
      inc_ext[i]  = (LEVEL_W+1)'(step_q[i]);
      inc_mag[i]  = inc_ext[i][LEVEL_W] ? -inc_ext[i] : inc_ext[i];
      level_nx[i] = level_q[i];
      if (level_q[i] != target_q[i]) begin
        if (adv_mag[i] > inc_mag[i]) begin
          level_nx[i] = level_q[i] + step_q[i];
        end else begin
          level_nx[i] = target_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        target_q[i] <= '0;
        step_q[i]   <= '0;
        level_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_CH; i++) begin
        if (cmd_i.load && (cmd_i.chan == chan_t'(i))) begin
          target_q[i] <= load_target;
        end
        if (cmd_i.store && (cmd_i.chan == chan_t'(i))) begin
          step_q[i] <= quo_signed;
        end
        if (cmd_i.advance) begin
          level_q[i] <= level_nx[i];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      red_out_o      <= level_q[0][LEVEL_SHIFT+COLOR_W-1:LEVEL_SHIFT];
      green_out_o    <= level_q[1][LEVEL_SHIFT+COLOR_W-1:LEVEL_SHIFT];
      blue_out_o     <= level_q[2][LEVEL_SHIFT+COLOR_W-1:LEVEL_SHIFT];
      pattern_done_o <= done_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/led_fade_pattern_sequencer.sv]
// Channel   Modport  Word contents
// in_i      sink     req_type, entry_index, RGB levels, header fields
// out_o     source   red_out, green_out, blue_out, pattern_done
//
// A write item takes effect on acceptance; its result then waits for out_o room.
// A tick runs ST_STEP, ST_ADVANCE, ST_RESULT; on a step to a new entry, the 3
// fade steps run in turn on the shared restoring divider before ST_ADVANCE.
// Reset clears the color table valid bits, the header and all player state.
// A new word is accepted while an earlier result still waits in out_o.
`timescale 1ns / 1ps
`include "led_fade_pattern_sequencer_macros.svh"

module led_fade_pattern_sequencer #(
  parameter int unsigned PATTERN_LEN = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lfps_in_if.sink   in_i,
  lfps_out_if.source out_o
);
  import lfps_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready = in_ready;

  lfps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfps_datapath #(
    .PATTERN_LEN (PATTERN_LEN)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (in_i.req_type),
    .entry_index_i  (in_i.entry_index),
    .red_level_i    (in_i.red_level),
    .green_level_i  (in_i.green_level),
    .blue_level_i   (in_i.blue_level),
    .step_period_i  (in_i.step_period),
    .fade_ticks_i   (in_i.fade_ticks),
    .repeat_limit_i (in_i.repeat_limit),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .red_out_o      (out_o.red_out),
    .green_out_o    (out_o.green_out),
    .blue_out_o     (out_o.blue_out),
    .pattern_done_o (out_o.pattern_done)
  );

  `LFPS_ASSERT_NEXT(a_one_word_at_a_time, in_i.valid && in_i.ready, !in_i.ready, "word accepted while busy")
  `LFPS_ASSERT_SAME(a_no_result_overwrite, cmd.load_out, !out_o.valid || out_o.ready, "result overwritten")
  `LFPS_ASSERT_SAME(a_idle_no_result, in_i.ready, !cmd.load_out && !cmd.advance, "idle controller issued work")

endmodule

[tb/led_fade_pattern_sequencer_test.sv]
`timescale 1ns / 1ps

module led_fade_pattern_sequencer_test;
  import lfps_pkg::*;

  localparam int unsigned TABLE_LEN     = 32;
  localparam int unsigned TOTAL_WORDS   = 1100;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned PRINT_LIMIT   = 40;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int READY_ALWAYS  = 0;
  localparam int READY_RANDOM  = 1;
  localparam int READY_PATTERN = 2;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [ENTRY_W-1:0] idx;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] period;
    logic [COLOR_W-1:0] fade;
    logic [COLOR_W-1:0] repeats;
    bit                 drain_first;
  } led_word_t;

  typedef struct {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               done;
  } led_color_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lfps_in_if  cmd_if ();
  lfps_out_if led_if ();

  led_fade_pattern_sequencer dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (led_if)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the pattern player.
  logic [RGB_W-1:0]   palette [TABLE_LEN];
  logic [COLOR_W-1:0] hdr_period;
  logic [COLOR_W-1:0] hdr_fade;
  logic [COLOR_W-1:0] hdr_repeat;
  bit                 restart_armed;
  bit                 done_seen;
  logic [COLOR_W-1:0] countdown;
  logic [COLOR_W-1:0] repeat_cnt;
  logic [ENTRY_W-1:0] pos;
  int                 fade_goal   [NUM_CH];
  int                 fade_stride [NUM_CH];
  int                 fade_now    [NUM_CH];

  led_word_t   pending_words [$];
  led_color_t  color_due [$];
  int          mismatches      = 0;
  int          results_checked = 0;
  bit          word_taken      = 1'b0;
  int          burst_left      = 0;
  int          gap_left        = 0;
  int          stall_mode      = READY_ALWAYS;
  int unsigned cycle_count     = 0;

  function automatic int to_level(int v);
    logic signed [LEVEL_W-1:0] t;
    t = v[LEVEL_W-1:0];
    return t;
  endfunction

  function automatic void begin_fade(int ch, logic [COLOR_W-1:0] c);
    int div;
    div = (hdr_fade != 0) ? int'(hdr_fade) : 1;
    fade_goal[ch]   = to_level(int'(c) << LEVEL_SHIFT);
    fade_stride[ch] = to_level((fade_goal[ch] - fade_now[ch]) / div);
  endfunction

  function automatic void move_level(int ch);
    int span;
    int inc;
    if (fade_now[ch] != fade_goal[ch]) begin
      span = fade_goal[ch] - fade_now[ch];
      if (span < 0) span = -span;
      inc = fade_stride[ch];
      if (inc < 0) inc = -inc;
      if (span > inc) fade_now[ch] = to_level(fade_now[ch] + fade_stride[ch]);
      else fade_now[ch] = fade_goal[ch];
    end
  endfunction

  function automatic void led_tick();
    logic [RGB_W-1:0] c;
    if (restart_armed) begin
      restart_armed = 1'b0;
      done_seen     = 1'b0;
      countdown     = '0;
      pos           = '0;
    end else begin
      if (countdown == 0) begin
        countdown = hdr_period;
        if (pos < TABLE_LEN - 1) begin
          done_seen  = 1'b0;
          pos        = pos + 1'b1;
          repeat_cnt = '0;
        end else begin
          done_seen = 1'b1;
          if (hdr_repeat != REPEAT_HOLD) begin
            repeat_cnt = repeat_cnt + 1'b1;
            if (repeat_cnt > hdr_repeat) pos = '0;
          end
        end
        c = palette[pos];
        begin_fade(CH_RED,   c[2*COLOR_W +: COLOR_W]);
        begin_fade(CH_GREEN, c[COLOR_W +: COLOR_W]);
        begin_fade(CH_BLUE,  c[0 +: COLOR_W]);
      end
      countdown = countdown - 1'b1;
    end
    for (int ch = 0; ch < NUM_CH; ch++) move_level(ch);
  endfunction

  function automatic led_color_t play_word(led_word_t w);
    led_color_t r;
    case (w.req)
      REQ_TICK: begin
        led_tick();
      end
      REQ_ENTRY: begin
        palette[w.idx] = {w.red, w.green, w.blue};
        restart_armed  = 1'b1;
      end
      REQ_HEADER: begin
        hdr_period    = w.period;
        hdr_fade      = w.fade;
        hdr_repeat    = w.repeats;
        restart_armed = 1'b1;
      end
      default: begin
      end
    endcase
    r.red   = COLOR_W'(fade_now[CH_RED] / (1 << LEVEL_SHIFT));
    r.green = COLOR_W'(fade_now[CH_GREEN] / (1 << LEVEL_SHIFT));
    r.blue  = COLOR_W'(fade_now[CH_BLUE] / (1 << LEVEL_SHIFT));
    r.done  = done_seen;
    return r;
  endfunction

  function automatic led_word_t noise_word();
    led_word_t w;
    w.req         = REQ_W'($urandom_range(0, 3));
    w.idx         = ENTRY_W'($urandom);
    w.red         = COLOR_W'($urandom);
    w.green       = COLOR_W'($urandom);
    w.blue        = COLOR_W'($urandom);
    w.period      = COLOR_W'($urandom);
    w.fade        = COLOR_W'($urandom);
    w.repeats     = COLOR_W'($urandom);
    w.drain_first = 1'b0;
    return w;
  endfunction

  function automatic void queue_tick();
    led_word_t w;
    w     = noise_word();
    w.req = REQ_TICK;
    pending_words.push_back(w);
  endfunction

  function automatic void queue_entry(logic [ENTRY_W-1:0] idx, logic [COLOR_W-1:0] r,
                                      logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
    led_word_t w;
    w       = noise_word();
    w.req   = REQ_ENTRY;
    w.idx   = idx;
    w.red   = r;
    w.green = g;
    w.blue  = b;
    pending_words.push_back(w);
  endfunction

  function automatic void queue_header(logic [COLOR_W-1:0] p, logic [COLOR_W-1:0] f,
                                       logic [COLOR_W-1:0] rep);
    led_word_t w;
    w         = noise_word();
    w.req     = REQ_HEADER;
    w.period  = p;
    w.fade    = f;
    w.repeats = rep;
    pending_words.push_back(w);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t: result %0d %s: got %0d, expected %0d", $time, results_checked, what,
               got, want);
    end
  endtask

  always @(posedge clk_i) begin : watch
    led_color_t got;
    led_color_t want;
    word_taken <= cmd_if.valid && cmd_if.ready;
    if (led_if.valid && led_if.ready) begin
      got.red   = led_if.red_out;
      got.green = led_if.green_out;
      got.blue  = led_if.blue_out;
      got.done  = led_if.pattern_done;
      if (color_due.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = color_due.pop_front();
        if (got.red !== want.red) report_mismatch("red", got.red, want.red);
        if (got.green !== want.green) report_mismatch("green", got.green, want.green);
        if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
        if (got.done !== want.done) report_mismatch("done", got.done, want.done);
      end
      results_checked++;
    end
    if (cmd_if.valid && cmd_if.ready) begin
      want.red   = 'x;
      color_due.push_back(play_word('{cmd_if.req_type, cmd_if.entry_index, cmd_if.red_level,
                                      cmd_if.green_level, cmd_if.blue_level,
                                      cmd_if.step_period, cmd_if.fade_ticks,
                                      cmd_if.repeat_limit, 1'b0}));
    end
  end

  always @(negedge clk_i) begin : feed
    led_word_t w;
    if (rst_ni && (!cmd_if.valid || word_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_if.valid <= 1'b0;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].drain_first && color_due.size() != 0)) begin
        cmd_if.valid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        cmd_if.req_type     <= w.req;
        cmd_if.entry_index  <= w.idx;
        cmd_if.red_level    <= w.red;
        cmd_if.green_level  <= w.green;
        cmd_if.blue_level   <= w.blue;
        cmd_if.step_period  <= w.period;
        cmd_if.fade_ticks   <= w.fade;
        cmd_if.repeat_limit <= w.repeats;
        cmd_if.valid        <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (cycle_count % 128 == 0) stall_mode = $urandom_range(READY_ALWAYS, READY_PATTERN);
    case (stall_mode)
      READY_RANDOM:  led_if.ready <= ($urandom_range(0, 2) != 0);
      READY_PATTERN: led_if.ready <= ((cycle_count % 7) < 4);
      default:       led_if.ready <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : main
    int n_entries;
    int pick;
    cmd_if.valid        = 1'b0;
    cmd_if.req_type     = REQ_TICK;
    cmd_if.entry_index  = '0;
    cmd_if.red_level    = '0;
    cmd_if.green_level  = '0;
    cmd_if.blue_level   = '0;
    cmd_if.step_period  = '0;
    cmd_if.fade_ticks   = '0;
    cmd_if.repeat_limit = '0;
    led_if.ready        = 1'b0;

    foreach (palette[i]) palette[i] = '0;
    hdr_period    = '0;
    hdr_fade      = '0;
    hdr_repeat    = '0;
    restart_armed = 1'b0;
    done_seen     = 1'b0;
    countdown     = '0;
    repeat_cnt    = '0;
    pos           = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      fade_goal[ch]   = 0;
      fade_stride[ch] = 0;
      fade_now[ch]    = 0;
    end

    // A tick straight out of reset steps at once, since no restart is armed.
    queue_tick();
    queue_header(8'd1, 8'd0, 8'd0);
    queue_entry(5'd0, 8'hFF, 8'hFF, 8'hFF);
    queue_entry(5'd1, 8'hFF, 8'h00, 8'h80);
    queue_entry(5'd31, 8'h00, 8'hFF, 8'h01);
    pending_words.push_back('{REQ_UNUSED, 5'h1F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                              1'b0});
    repeat (3) queue_tick();
    queue_header(8'd2, 8'd255, REPEAT_HOLD);
    pending_words[$].drain_first = 1'b1;
    repeat (4) queue_tick();
    queue_header(8'd0, 8'd1, 8'd254);
    repeat (3) queue_tick();
    queue_header(8'd255, 8'd128, 8'd1);
    queue_entry(5'd31, 8'h00, 8'h00, 8'h00);
    repeat (2) queue_tick();

    // Mostly a header and a few entries followed by a long run of ticks, so that
    // the player walks to the last entry and loops; the rest is loose noise.
    while (pending_words.size() < TOTAL_WORDS) begin
      if ($urandom_range(0, 9) < 7) begin
        n_entries = $urandom_range(0, 4);
        repeat (n_entries) begin
          queue_entry(($urandom_range(0, 3) == 0) ? 5'd31 : ENTRY_W'($urandom_range(0, 31)),
                      COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
        end
        if ($urandom_range(0, 9) < 7 || n_entries == 0) begin
          pick = $urandom_range(0, 9);
          queue_header(($urandom_range(0, 9) == 0) ? COLOR_W'($urandom_range(0, 255)) :
                                                     COLOR_W'($urandom_range(1, 3)),
                       ($urandom_range(0, 1) == 0) ? COLOR_W'($urandom_range(0, 255)) :
                                                     COLOR_W'($urandom_range(0, 4)),
                       (pick < 6) ? COLOR_W'($urandom_range(0, 3)) :
                       (pick < 8) ? REPEAT_HOLD : COLOR_W'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 15) == 0) pending_words[$].drain_first = 1'b1;
        repeat ($urandom_range(20, 110)) begin
          if ($urandom_range(0, 24) == 0) pending_words.push_back(noise_word());
          else queue_tick();
        end
      end else begin
        repeat ($urandom_range(1, 5)) pending_words.push_back(noise_word());
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || cmd_if.valid) @(posedge clk_i);
    while (color_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
